/* hdl/tlvp_pkg.sv */
// Shared types and constants of the TLV list response parser.
// No dependencies; every other file of the block but the two interfaces uses it.
package tlvp_pkg;

   localparam logic [7:0]  TYPE_LIST   = 8'h01;
   localparam logic [7:0]  TYPE_RESULT = 8'h02;
   localparam logic [15:0] RESULT_LEN  = 16'd4;
   localparam logic [15:0] COUNT_LEN   = 16'd4;
   localparam logic [2:0]  ENTRY_LAST  = 3'd4;
   localparam logic [7:0]  MAX_TAG     = 8'd3;

   localparam logic [15:0] MAX_ENTRIES_RESET = 16'hFFFF;

   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] ST_SUCCESS   = 2'd0;
   localparam logic [1:0] ST_SVC_FAIL  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One queue slot: results caused by one input item (entry, status or both).
   typedef struct packed {
      logic        entry_valid;
      logic [15:0] entry_position;
      logic [31:0] message_index;
      logic [1:0]  message_tag;
      logic        status_valid;
      logic [1:0]  status;
      logic [15:0] svc_error;
      logic [15:0] entry_count;
   } tlvp_event_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } tlvp_qstat_type;

endpackage

/* hdl/tlvp_req_if.sv */
// Request channel of the TLV list response parser: at most one response byte per transfer.
// Stands alone; used by the top level and the front parser.
interface tlvp_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       end_of_response;

   modport source (output valid, has_byte, data_byte, end_of_response, input ready);
   modport sink   (input valid, has_byte, data_byte, end_of_response, output ready);
endinterface

/* hdl/tlvp_rsp_if.sv */
// Result channel of the TLV list response parser: list entries and final status.
// Stands alone; used by the top level and the output stage.
interface tlvp_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [15:0] entry_position;
   logic [31:0] message_index;
   logic [1:0]  message_tag;
   logic [1:0]  status;
   logic [15:0] svc_error;
   logic [15:0] entry_count;
   logic        last_result;

   modport source (output valid, item_kind, entry_position, message_index, message_tag,
                   status, svc_error, entry_count, last_result, input ready);
   modport sink   (input valid, item_kind, entry_position, message_index, message_tag,
                   status, svc_error, entry_count, last_result, output ready);
endinterface

/* hdl/tlv_list_response_parser_top.sv */
// TLV list response parser, top level.
// req_if carries one response byte per transfer (has_byte, data_byte) and
// end_of_response on the last item of a response; an item may carry only the
// end marker. rsp_if delivers list entries (item_kind 0) once their fifth byte
// is taken, and one final status item (item_kind 1, last_result 1) for
// every end marker. Entries are speculative until that status says success.
// csr_we/csr_wdata write max_entries (reset 65535); write it only between
// responses.
// Throughput: one input item per cycle while the queue has room. The front
// parser updates its state in the cycle a byte is taken; the result event is
// written into the queue with the item's transfer and then loaded into the
// output register, which presents it on rsp_if. An item that completes an entry
// and ends the response yields two results, the entry and then the final status.
// A four-slot event queue sits between parser and output register, so the
// input keeps flowing while rsp_if is stalled; req_if.ready drops only when
// the queue is full. Reset (synchronous) clears the parse state, the queue and
// the output valid.
module tlv_list_response_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   tlvp_req_if.sink    req_if,
   tlvp_rsp_if.source  rsp_if
);

   tlvp_pkg::tlvp_event_type evt;
   tlvp_pkg::tlvp_event_type head;
   tlvp_pkg::tlvp_qstat_type qstat;
   logic                     pop;

   tlvp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .qstat     (qstat),
      .evt       (evt)
   );

   tlvp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_evt (evt),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   tlvp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .qstat  (qstat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (evt.entry_valid || evt.status_valid) |-> !qstat.full)
      else $error("event pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.not_empty)
      else $error("event popped from an empty queue");

   a_entry_fields_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.item_kind == tlvp_pkg::KIND_ENTRY) |->
      (rsp_if.status == tlvp_pkg::ST_SUCCESS && rsp_if.entry_count == 16'd0 &&
       rsp_if.svc_error == 16'd0))
      else $error("entry transfer carries status fields");

   a_full_stalls_input: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_if.ready)
      else $error("input ready while queue is full");
`endif

endmodule

/* hdl/tlvp_front.sv */
// Front parser: takes at most one byte per transfer, tracks records and builds result events.
// Depends on tlvp_pkg and tlvp_req_if.
module tlvp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [15:0]             csr_wdata,
   tlvp_req_if.sink                req_if,
   input  tlvp_pkg::tlvp_qstat_type qstat,
   output tlvp_pkg::tlvp_event_type evt
);

   typedef enum logic [1:0] {
      HDR_TYPE   = 2'd0,
      HDR_LEN_LO = 2'd1,
      HDR_LEN_HI = 2'd2,
      HDR_VALUE  = 2'd3
   } hdr_state_type;

   hdr_state_type hdr_pos_ff, hdr_pos_in;
   logic [7:0]  rec_type_ff, rec_type_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic [15:0] val_pos_ff, val_pos_in;
   logic        res_found_ff, res_found_in;
   logic        res_bad_ff, res_bad_in;
   logic [31:0] res_word_ff, res_word_in;
   logic        list_found_ff, list_found_in;
   logic        list_bad_ff, list_bad_in;
   logic        in_list_ff, in_list_in;
   logic [31:0] list_count_ff, list_count_in;
   logic        count_ok_ff, count_ok_in;
   logic [2:0]  entry_k_ff, entry_k_in;
   logic [31:0] entry_idx_ff, entry_idx_in;
   logic [15:0] entries_done_ff, entries_done_in;
   logic        tag_bad_ff, tag_bad_in;
   logic [15:0] max_entries_ff;

   logic        accept;
   logic        take;
   logic        eor;
   logic        emit;
   logic        complete;
   logic [7:0]  b;
   logic [15:0] len_full;
   logic [15:0] val_pos_next;
   logic [31:0] lc_new;
   logic [34:0] lc_times5;
   logic [15:0] len_m4;
   logic        truncated;
   logic [1:0]  st;
   logic [15:0] se;
   logic [15:0] cnt;

   assign req_if.ready = !qstat.full;
   assign accept       = req_if.valid && req_if.ready;
   assign take         = accept && req_if.has_byte;
   assign eor          = accept && req_if.end_of_response;
   assign b            = req_if.data_byte;
   assign len_full     = {b, rec_len_ff[7:0]};
   assign val_pos_next = val_pos_ff + 16'd1;
   assign lc_new       = {b, list_count_ff[23:0]};
   assign lc_times5    = {1'b0, lc_new, 2'b00} + {3'b000, lc_new};
   assign len_m4       = rec_len_ff - tlvp_pkg::COUNT_LEN;

   always_comb begin
      hdr_pos_in      = hdr_pos_ff;
      rec_type_in     = rec_type_ff;
      rec_len_in      = rec_len_ff;
      val_pos_in      = val_pos_ff;
      res_found_in    = res_found_ff;
      res_bad_in      = res_bad_ff;
      res_word_in     = res_word_ff;
      list_found_in   = list_found_ff;
      list_bad_in     = list_bad_ff;
      in_list_in      = in_list_ff;
      list_count_in   = list_count_ff;
      count_ok_in     = count_ok_ff;
      entry_k_in      = entry_k_ff;
      entry_idx_in    = entry_idx_ff;
      entries_done_in = entries_done_ff;
      tag_bad_in      = tag_bad_ff;
      emit            = 1'b0;
      complete        = 1'b0;
      if (take) begin
         unique case (hdr_pos_ff)
            HDR_TYPE: begin
               rec_type_in = b;
               hdr_pos_in  = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
               rec_len_in = {8'h00, b};
               hdr_pos_in = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
               rec_len_in = len_full;
               val_pos_in = 16'd0;
               if (rec_type_ff == tlvp_pkg::TYPE_LIST && !list_found_ff) begin
                  in_list_in      = 1'b1;
                  list_count_in   = 32'd0;
                  count_ok_in     = 1'b0;
                  entry_k_in      = 3'd0;
                  entry_idx_in    = 32'd0;
                  entries_done_in = 16'd0;
                  tag_bad_in      = 1'b0;
               end
               if (len_full == 16'd0) begin
                  complete = 1'b1;
               end else begin
                  hdr_pos_in = HDR_VALUE;
               end
            end
            HDR_VALUE: begin
               if (rec_type_ff == tlvp_pkg::TYPE_RESULT && !res_found_ff &&
                   val_pos_ff < tlvp_pkg::RESULT_LEN) begin
                  res_word_in[val_pos_ff[1:0]*8 +: 8] = b;
               end
               if (in_list_ff) begin
                  if (val_pos_ff < tlvp_pkg::COUNT_LEN) begin
                     list_count_in[val_pos_ff[1:0]*8 +: 8] = b;
                     // Record is at least four bytes here, so len_m4 does not wrap
                     if (val_pos_ff[1:0] == 2'd3) begin
                        count_ok_in = (lc_new <= {16'h0000, max_entries_ff}) &&
                                      (lc_times5 <= {19'd0, len_m4});
                     end
                  end else if (entry_k_ff == tlvp_pkg::ENTRY_LAST) begin
                     entry_k_in = 3'd0;
                     if (count_ok_ff && !tag_bad_ff &&
                         ({16'h0000, entries_done_ff} < list_count_ff)) begin
                        if (b > tlvp_pkg::MAX_TAG) begin
                           tag_bad_in = 1'b1;
                        end else begin
                           emit            = 1'b1;
                           entries_done_in = entries_done_ff + 16'd1;
                        end
                     end
                  end else begin
                     entry_idx_in[entry_k_ff[1:0]*8 +: 8] = b;
                     entry_k_in = entry_k_ff + 3'd1;
                  end
               end
               val_pos_in = val_pos_next;
               if (val_pos_next == rec_len_ff) begin
                  complete = 1'b1;
               end
            end
            default: hdr_pos_in = HDR_TYPE;
         endcase
         if (complete) begin
            if (rec_type_ff == tlvp_pkg::TYPE_RESULT && !res_found_ff) begin
               res_found_in = 1'b1;
               res_bad_in   = (rec_len_in != tlvp_pkg::RESULT_LEN);
            end
            if (in_list_in) begin
               list_found_in = 1'b1;
               list_bad_in   = (rec_len_in < tlvp_pkg::COUNT_LEN);
               in_list_in    = 1'b0;
            end
            hdr_pos_in = HDR_TYPE;
         end
      end
   end

   // Final status from the state after this item's byte
   always_comb begin
      truncated = (hdr_pos_in != HDR_TYPE);
      se        = 16'd0;
      cnt       = 16'd0;
      priority if (!res_found_in || res_bad_in) begin
         st = tlvp_pkg::ST_MALFORMED;
      end else begin
         se = res_word_in[31:16];
         priority if (res_word_in[15:0] != 16'd0) begin
            st = tlvp_pkg::ST_SVC_FAIL;
         end else if (!list_found_in) begin
            st = truncated ? tlvp_pkg::ST_MALFORMED : tlvp_pkg::ST_SUCCESS;
         end else if (list_bad_in) begin
            st = tlvp_pkg::ST_MALFORMED;
         end else if (!count_ok_in) begin
            st = tlvp_pkg::ST_OVERFLOW;
         end else if (tag_bad_in) begin
            st = tlvp_pkg::ST_MALFORMED;
         end else begin
            st  = tlvp_pkg::ST_SUCCESS;
            cnt = list_count_in[15:0];
         end
      end
   end

   always_comb begin
      evt.entry_valid    = emit;
      evt.entry_position = entries_done_ff;
      evt.message_index  = entry_idx_ff;
      evt.message_tag    = b[1:0];
      evt.status_valid   = eor;
      evt.status         = st;
      evt.svc_error      = se;
      evt.entry_count    = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= tlvp_pkg::MAX_ENTRIES_RESET;
      end else if (csr_we) begin
         max_entries_ff <= csr_wdata;
      end
      // Drop all parse state after the final status
      if (reset || eor) begin
         hdr_pos_ff      <= HDR_TYPE;
         rec_type_ff     <= 8'd0;
         rec_len_ff      <= 16'd0;
         val_pos_ff      <= 16'd0;
         res_found_ff    <= 1'b0;
         res_bad_ff      <= 1'b0;
         res_word_ff     <= 32'd0;
         list_found_ff   <= 1'b0;
         list_bad_ff     <= 1'b0;
         in_list_ff      <= 1'b0;
         list_count_ff   <= 32'd0;
         count_ok_ff     <= 1'b0;
         entry_k_ff      <= 3'd0;
         entry_idx_ff    <= 32'd0;
         entries_done_ff <= 16'd0;
         tag_bad_ff      <= 1'b0;
      end else begin
         hdr_pos_ff      <= hdr_pos_in;
         rec_type_ff     <= rec_type_in;
         rec_len_ff      <= rec_len_in;
         val_pos_ff      <= val_pos_in;
         res_found_ff    <= res_found_in;
         res_bad_ff      <= res_bad_in;
         res_word_ff     <= res_word_in;
         list_found_ff   <= list_found_in;
         list_bad_ff     <= list_bad_in;
         in_list_ff      <= in_list_in;
         list_count_ff   <= list_count_in;
         count_ok_ff     <= count_ok_in;
         entry_k_ff      <= entry_k_in;
         entry_idx_ff    <= entry_idx_in;
         entries_done_ff <= entries_done_in;
         tag_bad_ff      <= tag_bad_in;
      end
   end

endmodule

/* hdl/tlvp_fifo.sv */
// Short event queue between the front parser and the output stage.
// Depends on tlvp_pkg.
module tlvp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  tlvp_pkg::tlvp_event_type  push_evt,
   input  logic                     pop,
   output tlvp_pkg::tlvp_event_type  head,
   output tlvp_pkg::tlvp_qstat_type  qstat
);

   tlvp_pkg::tlvp_event_type slot_ff [tlvp_pkg::QUEUE_DEPTH];

   logic [tlvp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tlvp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tlvp_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          push;
   logic                          do_pop;

   localparam logic [tlvp_pkg::QUEUE_AW:0] DEPTH_W = (tlvp_pkg::QUEUE_AW + 1)'(tlvp_pkg::QUEUE_DEPTH);
   localparam logic [tlvp_pkg::QUEUE_AW-1:0] LAST_W = tlvp_pkg::QUEUE_AW'(tlvp_pkg::QUEUE_DEPTH - 1);

   assign push            = push_evt.entry_valid || push_evt.status_valid;
   assign do_pop          = pop && (count_ff != '0);
   assign qstat.full      = (count_ff == DEPTH_W);
   assign qstat.not_empty = (count_ff != '0);
   assign head            = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_W) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_W) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

endmodule

/* hdl/tlvp_back.sv */
// Output stage: splits queued events into entry and status transfers.
// Depends on tlvp_pkg and tlvp_rsp_if.
module tlvp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  tlvp_pkg::tlvp_event_type  head,
   input  tlvp_pkg::tlvp_qstat_type  qstat,
   output logic                     pop,
   tlvp_rsp_if.source               rsp_if
);

   logic        valid_ff;
   logic        entry_sent_ff, entry_sent_in;
   logic        kind_ff, kind_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] idx_ff, idx_in;
   logic [1:0]  tag_ff, tag_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] se_ff, se_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        load;
   logic        send_entry;

   assign load       = qstat.not_empty && (!valid_ff || rsp_if.ready);
   assign send_entry = head.entry_valid && !entry_sent_ff;
   // Hold the slot while its status still has to follow the entry
   assign pop        = load && !(send_entry && head.status_valid);

   always_comb begin
      entry_sent_in = entry_sent_ff;
      if (send_entry) begin
         kind_in       = tlvp_pkg::KIND_ENTRY;
         pos_in        = head.entry_position;
         idx_in        = head.message_index;
         tag_in        = head.message_tag;
         st_in         = tlvp_pkg::ST_SUCCESS;
         se_in         = 16'd0;
         cnt_in        = 16'd0;
         if (load) begin
            entry_sent_in = head.status_valid;
         end
      end else begin
         kind_in = tlvp_pkg::KIND_STATUS;
         pos_in  = 16'd0;
         idx_in  = 32'd0;
         tag_in  = 2'd0;
         st_in   = head.status;
         se_in   = head.svc_error;
         cnt_in  = head.entry_count;
         if (load) begin
            entry_sent_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         entry_sent_ff <= 1'b0;
      end else begin
         entry_sent_ff <= entry_sent_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (load) begin
         kind_ff <= kind_in;
         pos_ff  <= pos_in;
         idx_ff  <= idx_in;
         tag_ff  <= tag_in;
         st_ff   <= st_in;
         se_ff   <= se_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.item_kind      = kind_ff;
   assign rsp_if.entry_position = pos_ff;
   assign rsp_if.message_index  = idx_ff;
   assign rsp_if.message_tag    = tag_ff;
   assign rsp_if.status         = st_ff;
   assign rsp_if.svc_error      = se_ff;
   assign rsp_if.entry_count    = cnt_ff;
   assign rsp_if.last_result    = (kind_ff == tlvp_pkg::KIND_STATUS);

endmodule

/* tb/sv/tlvp_check_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard of the TLV list response parser testbench: a byte-level predictor
// of list entries and final status, and an in-order compare of the results.
// Depends on tlvp_pkg.
package tlvp_check_pkg;
   import tlvp_pkg::*;

   localparam int ENTRY_BYTES = 5;

   // Where the parser stands within a record.
   localparam logic [1:0] HDR_TYPE   = 2'd0;
   localparam logic [1:0] HDR_LEN_LO = 2'd1;
   localparam logic [1:0] HDR_LEN_HI = 2'd2;
   localparam logic [1:0] HDR_VALUE  = 2'd3;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_response;
   } req_item_t;

   typedef struct packed {
      logic        item_kind;
      logic [15:0] entry_position;
      logic [31:0] message_index;
      logic [1:0]  message_tag;
      logic [1:0]  status;
      logic [15:0] svc_error;
      logic [15:0] entry_count;
      logic        last_result;
   } rsp_item_t;

   class tlv_response_scoreboard;
      logic [15:0] max_entries;
      logic [1:0]  hdr_pos;
      logic [7:0]  rec_type;
      logic [15:0] rec_len;
      logic [15:0] val_pos;
      bit          result_found;
      bit          result_malformed;
      logic [31:0] result_word;
      bit          list_found;
      bit          list_malformed;
      bit          in_list;
      logic [31:0] list_count;
      bit          count_ok;
      logic [39:0] entry_buf;
      logic [15:0] entries_done;
      bit          tag_bad;

      rsp_item_t   expected_q[$];
      int          errors;
      int          checked;
      int          entries_checked;
      int          status_seen[4];

      function new();
         max_entries = MAX_ENTRIES_RESET;
         errors = 0;
         checked = 0;
         entries_checked = 0;
         status_seen = '{default: 0};
         clear_parse();
      endfunction

      function void clear_parse();
         hdr_pos = HDR_TYPE;
         rec_type = '0;
         rec_len = '0;
         val_pos = '0;
         result_found = 1'b0;
         result_malformed = 1'b0;
         result_word = '0;
         list_found = 1'b0;
         list_malformed = 1'b0;
         in_list = 1'b0;
         list_count = '0;
         count_ok = 1'b0;
         entry_buf = '0;
         entries_done = '0;
         tag_bad = 1'b0;
      endfunction

      function void set_max_entries(logic [15:0] value);
         max_entries = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void complete_record();
         if (rec_type == TYPE_RESULT && !result_found) begin
            result_found = 1'b1;
            result_malformed = (rec_len != RESULT_LEN);
         end
         if (in_list) begin
            list_found = 1'b1;
            list_malformed = (rec_len < COUNT_LEN);
            in_list = 1'b0;
         end
         hdr_pos = HDR_TYPE;
      endfunction

      function void take_byte(logic [7:0] b);
         int unsigned pos;
         int unsigned k;
         logic [7:0]  tag;
         rsp_item_t   e;
         case (hdr_pos)
            HDR_TYPE: begin
               rec_type = b;
               hdr_pos = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
               rec_len = {8'h00, b};
               hdr_pos = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
               rec_len[15:8] = b;
               val_pos = '0;
               // only the first list record is parsed
               if (rec_type == TYPE_LIST && !list_found) begin
                  in_list = 1'b1;
                  list_count = '0;
                  count_ok = 1'b0;
                  entry_buf = '0;
                  entries_done = '0;
                  tag_bad = 1'b0;
               end
               if (rec_len == 16'd0) begin
                  complete_record();
               end else begin
                  hdr_pos = HDR_VALUE;
               end
            end
            default: begin
               pos = val_pos;
               if (rec_type == TYPE_RESULT && !result_found && pos < 4) begin
                  result_word |= 32'(b) << (8 * pos);
               end
               if (in_list) begin
                  if (pos < 4) begin
                     list_count |= 32'(b) << (8 * pos);
                     // count must fit both the record and the register
                     if (pos == 3) begin
                        count_ok = (list_count <= (32'(rec_len) - 32'(COUNT_LEN))
                                                  / 32'(ENTRY_BYTES))
                                   && (list_count <= 32'(max_entries));
                     end
                  end else begin
                     k = (pos - 4) % ENTRY_BYTES;
                     if (k == 0) begin
                        entry_buf = 40'(b);
                     end else begin
                        entry_buf |= 40'(b) << (8 * k);
                     end
                     if (k == 32'(ENTRY_LAST) && count_ok && !tag_bad &&
                         32'(entries_done) < list_count) begin
                        tag = entry_buf[39:32];
                        if (tag > MAX_TAG) begin
                           tag_bad = 1'b1;
                        end else begin
                           e = '0;
                           e.item_kind = KIND_ENTRY;
                           e.entry_position = entries_done;
                           e.message_index = entry_buf[31:0];
                           e.message_tag = tag[1:0];
                           expected_q.push_back(e);
                           entries_done = entries_done + 16'd1;
                        end
                     end
                  end
               end
               val_pos = val_pos + 16'd1;
               if (val_pos == rec_len) begin
                  complete_record();
               end
            end
         endcase
      endfunction

      function void close_response();
         rsp_item_t s;
         s = '0;
         s.item_kind = KIND_STATUS;
         s.last_result = 1'b1;
         if (!result_found || result_malformed) begin
            s.status = ST_MALFORMED;
         end else begin
            s.svc_error = result_word[31:16];
            if (result_word[15:0] != 16'd0) begin
               s.status = ST_SVC_FAIL;
            end else if (!list_found) begin
               // a missing list is fine unless the response was cut short
               s.status = (hdr_pos != HDR_TYPE) ? ST_MALFORMED : ST_SUCCESS;
            end else if (list_malformed) begin
               s.status = ST_MALFORMED;
            end else if (!count_ok) begin
               s.status = ST_OVERFLOW;
            end else if (tag_bad) begin
               s.status = ST_MALFORMED;
            end else begin
               s.status = ST_SUCCESS;
               s.entry_count = list_count[15:0];
            end
         end
         expected_q.push_back(s);
         clear_parse();
      endfunction

      // Call once per accepted input transfer.
      function void note_input(req_item_t it);
         if (it.has_byte) begin
            take_byte(it.data_byte);
         end
         if (it.end_of_response) begin
            close_response();
         end
      endfunction

      task report(string msg);
         $display("mismatch at result %0d: %s", checked, msg);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
         end
      endtask

      task check_result(rsp_item_t got);
         rsp_item_t want;
         checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result, kind %0d status %0d",
                             got.item_kind, got.status));
            return;
         end
         want = expected_q.pop_front();
         compare_field("item_kind", got.item_kind, want.item_kind);
         compare_field("entry_position", got.entry_position, want.entry_position);
         compare_field("message_index", got.message_index, want.message_index);
         compare_field("message_tag", got.message_tag, want.message_tag);
         compare_field("status", got.status, want.status);
         compare_field("svc_error", got.svc_error, want.svc_error);
         compare_field("entry_count", got.entry_count, want.entry_count);
         compare_field("last_result", got.last_result, want.last_result);
         if (want.item_kind == KIND_ENTRY) begin
            entries_checked++;
         end else begin
            status_seen[want.status]++;
         end
      endtask

      task flag_leftovers();
         if (expected_q.size() != 0) begin
            report($sformatf("%0d expected results never arrived", expected_q.size()));
         end
      endtask
   endclass

endpackage

/* tb/sv/tb_tlv_list_response_parser_top.sv */
`timescale 1ns / 1ps
// Testbench top of the TLV list response parser: builds byte-level responses,
// drives them with random gaps (none in the steady phase) and checks every result in order.
// Depends on tlvp_pkg, tlvp_req_if, tlvp_rsp_if and tlvp_check_pkg.
module tb_tlv_list_response_parser_top;
   import tlvp_pkg::*;
   import tlvp_check_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PERCENT  = 31;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   tlvp_req_if req_bus ();
   tlvp_rsp_if rsp_bus ();

   tlv_list_response_parser_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   tlv_response_scoreboard sb;
   logic [7:0]  resp_bytes[$];
   rsp_item_t   seen;
   bit          steady;
   int unsigned stall_cycles;
   int unsigned items_sent;
   int unsigned responses_sent;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.item_kind = rsp_bus.item_kind;
         seen.entry_position = rsp_bus.entry_position;
         seen.message_index = rsp_bus.message_index;
         seen.message_tag = rsp_bus.message_tag;
         seen.status = rsp_bus.status;
         seen.svc_error = rsp_bus.svc_error;
         seen.entry_count = rsp_bus.entry_count;
         seen.last_result = rsp_bus.last_result;
         sb.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("[tlv_list_response_parser_top] ERROR");
         $finish;
      end
   end

   function automatic req_item_t make_item(logic hb, logic [7:0] db, logic eor);
      req_item_t it;
      it.has_byte = hb;
      it.data_byte = db;
      it.end_of_response = eor;
      return it;
   endfunction

   function automatic void push_header(logic [7:0] rec, logic [15:0] len);
      resp_bytes.push_back(rec);
      resp_bytes.push_back(len[7:0]);
      resp_bytes.push_back(len[15:8]);
   endfunction

   function automatic void push_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) begin
         resp_bytes.push_back(w[8*i +: 8]);
      end
   endfunction

   // Mostly well-formed responses with random content, plus broken ones.
   function automatic void make_response();
      int unsigned result_slot;
      int unsigned list_slot;
      int unsigned n;
      int unsigned len;
      int unsigned extra;
      int unsigned cut;
      int unsigned r;
      logic [31:0] word;
      logic [31:0] count;
      resp_bytes.delete();
      // slot 4 never comes up: that record is left out
      result_slot = ($urandom_range(99) < 92) ? $urandom_range(3) : 4;
      list_slot = ($urandom_range(99) < 85) ? $urandom_range(3) : 4;
      for (int slot = 0; slot < 4; slot++) begin
         if (slot == result_slot) begin
            len = 4;
            if ($urandom_range(99) < 6) begin
               do len = $urandom_range(6); while (len == 4);
            end
            word[15:0] = ($urandom_range(99) < 15) ? 16'($urandom_range(1, 65535)) : 16'd0;
            word[31:16] = 16'($urandom);
            push_header(TYPE_RESULT, 16'(len));
            for (int i = 0; i < len; i++) begin
               resp_bytes.push_back((i < 4) ? word[8*i +: 8] : 8'($urandom));
            end
         end
         if (slot == list_slot) begin
            n = ($urandom_range(99) < 10) ? $urandom_range(5, 12) : $urandom_range(4);
            r = $urandom_range(99);
            if (r < 68) begin
               count = n;
            end else if (r < 78) begin
               count = n + $urandom_range(1, 3);
            end else if (r < 86) begin
               count = $urandom;
            end else begin
               count = $urandom_range(n);
            end
            extra = ($urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
            if ($urandom_range(99) < 5) begin
               len = $urandom_range(3);
               push_header(TYPE_LIST, 16'(len));
               repeat (len) resp_bytes.push_back(8'($urandom));
            end else begin
               push_header(TYPE_LIST, 16'(4 + ENTRY_BYTES * n + extra));
               push_word(count);
               repeat (n) begin
                  push_word($urandom);
                  resp_bytes.push_back(($urandom_range(99) < 4) ? 8'($urandom_range(4, 255))
                                                                 : 8'($urandom_range(3)));
               end
               repeat (extra) resp_bytes.push_back(8'($urandom));
            end
         end
         // unrelated records, and repeats of the two searched types
         if ($urandom_range(99) < 30) begin
            r = $urandom_range(99);
            len = $urandom_range(6);
            push_header((r < 10) ? TYPE_LIST : (r < 20) ? TYPE_RESULT : 8'($urandom),
                        16'(len));
            repeat (len) resp_bytes.push_back(8'($urandom));
         end
      end
      // cut the response short now and then
      if ($urandom_range(99) < 8 && resp_bytes.size() > 0) begin
         cut = $urandom_range(resp_bytes.size() - 1);
         while (resp_bytes.size() > cut) void'(resp_bytes.pop_back());
      end
   endfunction

   task automatic send_item(req_item_t it);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.has_byte <= it.has_byte;
      req_bus.data_byte <= it.data_byte;
      req_bus.end_of_response <= it.end_of_response;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(it);
      if (it.has_byte || it.end_of_response) begin
         items_sent++;
      end
   endtask

   task automatic send_response(bit end_alone);
      int last;
      last = resp_bytes.size();
      foreach (resp_bytes[i]) begin
         if ($urandom_range(99) < 4) begin
            send_item(make_item(1'b0, 8'($urandom), 1'b0));
         end
         send_item(make_item(1'b1, resp_bytes[i], !end_alone && i == last - 1));
      end
      if (end_alone || last == 0) begin
         send_item(make_item(1'b0, 8'($urandom), 1'b1));
      end
      responses_sent++;
   endtask

   // Hold the input until every expected result is out and the pipe is empty.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_entries(logic [15:0] value);
      drain();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_max_entries(value);
   endtask

   task automatic run_phase(logic [15:0] limit, int unsigned item_count, bit no_idle);
      int unsigned start;
      write_max_entries(limit);
      steady = no_idle;
      start = items_sent;
      while (items_sent - start < item_count) begin
         make_response();
         send_response($urandom_range(99) < 30);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.has_byte = 1'b0;
      req_bus.data_byte = '0;
      req_bus.end_of_response = 1'b0;
      steady = 1'b0;
      items_sent = 0;
      responses_sent = 0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty response, then an item that carries nothing
      send_item(make_item(1'b0, 8'hFF, 1'b1));
      send_item(make_item(1'b0, 8'h00, 1'b0));
      // success with one entry at the field extremes; end rides on its last byte
      resp_bytes.delete();
      push_header(TYPE_RESULT, RESULT_LEN);
      push_word(32'hFFFF_0000);
      push_header(TYPE_LIST, 16'(4 + ENTRY_BYTES));
      push_word(32'd1);
      push_word(32'hFFFF_FFFF);
      resp_bytes.push_back(MAX_TAG);
      send_response(1'b0);
      // zero-length result record, end marker on its own
      resp_bytes.delete();
      push_header(TYPE_RESULT, 16'd0);
      send_response(1'b1);

      run_phase(16'd3, 110, 1'b0);
      run_phase(16'd0, 90, 1'b0);
      run_phase(MAX_ENTRIES_RESET, 110, 1'b1);
      run_phase(16'($urandom_range(1, 10)), 100, 1'b0);

      drain();
      sb.flag_leftovers();
      $display("ran %0d responses in %0d input items; checked %0d results, %0d of them entries",
               responses_sent, items_sent, sb.checked, sb.entries_checked);
      $display("final status: %0d success, %0d service failure, %0d malformed, %0d overflow",
               sb.status_seen[ST_SUCCESS], sb.status_seen[ST_SVC_FAIL],
               sb.status_seen[ST_MALFORMED], sb.status_seen[ST_OVERFLOW]);
      if (sb.errors == 0) begin
         $display("[tlv_list_response_parser_top] OK");
      end else begin
         $display("[tlv_list_response_parser_top] ERROR");
      end
      $finish;
   end

endmodule
